FILE: rtl/core/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types, codes and character constants of the HTTP request parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

	localparam int FIELD_W     = 17;
	localparam int CHUNK_W     = 32;
	localparam int MKEEP       = 7;
	localparam int CLEN_W      = 27;
	localparam int NUM_METHODS = 7;

	typedef enum logic [4:0] {
		S_INIT, S_METHOD, S_METHOD_END, S_PATH, S_QUERY, S_PATH_END, S_VERSION,
		S_VERSION_CR, S_VERSION_LF, S_HNAME, S_HCOLON, S_HVALUE, S_HCR, S_HLF,
		S_HEND_CR, S_BODY, S_CSIZE, S_CSIZE_CR, S_CSIZE_LF, S_CDATA, S_CDATA_CR,
		S_CDATA_LF, S_TR_CR, S_TR_LF, S_TR_SKIP, S_TR_SKIP_LF, S_COMPLETE
	} state_t;

	localparam logic [2:0] CFG_METHOD  = 3'd0;
	localparam logic [2:0] CFG_PATH    = 3'd1;
	localparam logic [2:0] CFG_QUERY   = 3'd2;
	localparam logic [2:0] CFG_VERSION = 3'd3;
	localparam logic [2:0] CFG_HFIELD  = 3'd4;
	localparam logic [2:0] CFG_CLEN    = 3'd5;
	localparam logic [2:0] CFG_CDIGITS = 3'd6;

	localparam logic [2:0] CLS_SKIP    = 3'd0;
	localparam logic [2:0] CLS_METHOD  = 3'd1;
	localparam logic [2:0] CLS_PATH    = 3'd2;
	localparam logic [2:0] CLS_QUERY   = 3'd3;
	localparam logic [2:0] CLS_VERSION = 3'd4;
	localparam logic [2:0] CLS_HNAME   = 3'd5;
	localparam logic [2:0] CLS_HVALUE  = 3'd6;
	localparam logic [2:0] CLS_BODY    = 3'd7;

	localparam logic [1:0] ST_MORE     = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_ERROR    = 2'd2;

	localparam logic [2:0] M_GET = 3'd0;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_C     = 8'h63;

	localparam logic [0:13][7:0] NAME_CL      = "content-length";
	localparam logic [0:16][7:0] NAME_TE      = "transfer-encoding";
	localparam logic [0:6][7:0]  WORD_CHUNKED = "chunked";

	localparam logic [0:NUM_METHODS-1][0:MKEEP-1][7:0] METHOD_NAMES = {
		{"GET", 32'h0}, {"POST", 24'h0}, {"PUT", 32'h0}, {"DELETE", 8'h0},
		{"HEAD", 24'h0}, "OPTIONS", {"PATCH", 16'h0}
	};
	localparam logic [0:NUM_METHODS-1][FIELD_W-1:0] METHOD_LENS = {
		17'd3, 17'd4, 17'd3, 17'd6, 17'd4, 17'd7, 17'd5
	};

	typedef struct packed {
		logic [5:0]        max_method;
		logic [13:0]       max_path;
		logic [13:0]       max_query;
		logic [4:0]        max_version;
		logic [16:0]       max_hfield;
		logic [CLEN_W-1:0] max_clen;
		logic [5:0]        max_cdigits;
	} cfg_t;

	typedef struct packed {
		state_t                  state;
		logic [FIELD_W-1:0]      flen;
		logic [0:MKEEP-1][7:0]   mbytes;
		logic [2:0]              method;
		logic [1:0]              nflags;
		logic [CLEN_W-1:0]       dacc;
		logic                    dvalid;
		logic [2:0]              cpos;
		logic [CLEN_W-1:0]       clen;
		logic                    chunked;
		logic [CLEN_W-1:0]       bcount;
		logic [CHUNK_W-1:0]      csize;
		logic [CHUNK_W-1:0]      ccount;
		logic                    err;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{state: S_INIT, method: M_GET, nflags: 2'b11,
		dvalid: 1'b1, default: '0};

	typedef struct packed {
		logic [2:0]        cls;
		logic [7:0]        obyte;
		logic [1:0]        status;
		logic [2:0]        method;
		logic [CLEN_W-1:0] clen;
		logic              chunked;
		logic              hl;
		logic              hd;
	} res_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
		if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
		if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
		return 5'd0;
	endfunction

endpackage

FILE: rtl/core/hrsp_cfg_regs.sv
// ----------------------------------------------------------------------------
// hrsp_cfg_regs
// Limit registers of the parser, written through a plain write port.
// ----------------------------------------------------------------------------
module hrsp_cfg_regs import hrsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [26:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_method  <= 6'd32;
			cfg_q.max_path    <= 14'd8192;
			cfg_q.max_query   <= 14'd8192;
			cfg_q.max_version <= 5'd16;
			cfg_q.max_hfield  <= 17'd65536;
			cfg_q.max_clen    <= 27'd104857600;
			cfg_q.max_cdigits <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_METHOD:  cfg_q.max_method  <= cfg_wdata[5:0];
				CFG_PATH:    cfg_q.max_path    <= cfg_wdata[13:0];
				CFG_QUERY:   cfg_q.max_query   <= cfg_wdata[13:0];
				CFG_VERSION: cfg_q.max_version <= cfg_wdata[4:0];
				CFG_HFIELD:  cfg_q.max_hfield  <= cfg_wdata[16:0];
				CFG_CLEN:    cfg_q.max_clen    <= cfg_wdata;
				CFG_CDIGITS: cfg_q.max_cdigits <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/hrsp_step.sv
// ----------------------------------------------------------------------------
// hrsp_step
// Next-context and result logic for one request byte.
// ----------------------------------------------------------------------------
module hrsp_step import hrsp_pkg::*; (
	input  ctx_t       ctx,
	input  cfg_t       cfg,
	input  logic       action,
	input  logic [7:0] data_byte,
	output ctx_t       ctx_next,
	output res_t       res
);

	ctx_t       n;
	logic [2:0] cls;
	logic       fail;
	logic       hl;
	logic       hd;

	always_comb begin
		logic [7:0]        b;
		logic [7:0]        lb;
		logic [4:0]        hx;
		logic [CLEN_W+3:0] dv;
		logic [FIELD_W-1:0] p;
		n    = ctx;
		cls  = CLS_SKIP;
		fail = 1'b0;
		hl   = 1'b0;
		hd   = 1'b0;
		b    = data_byte;
		lb   = to_lower(data_byte);
		hx   = hex_value(data_byte);
		p    = ctx.flen;
		dv   = '0;
		if (action) begin
			n = CTX_RESET;
		end else if (!ctx.err) begin
			unique case (ctx.state) inside
				S_INIT: begin
					n.state = S_METHOD;
					n.flen  = '0;
				end
				S_METHOD_END: if (b != CH_SP) begin
					n.state = S_PATH;
					n.flen  = '0;
				end
				S_PATH_END: if (b != CH_SP) begin
					n.state = S_VERSION;
					n.flen  = '0;
				end
				S_VERSION_LF, S_HLF: if (b != CH_CR) begin
					n.state  = S_HNAME;
					n.flen   = '0;
					n.nflags = 2'b11;
				end
				S_HCOLON: if (b != CH_SP) begin
					n.state  = S_HVALUE;
					n.flen   = '0;
					n.dacc   = '0;
					n.dvalid = 1'b1;
					n.cpos   = '0;
				end
				S_CSIZE_LF: begin
					if (ctx.csize == '0) begin
						n.state = S_TR_CR;
					end else begin
						n.state  = S_CDATA;
						n.ccount = '0;
					end
				end
				default: ;
			endcase
			p = n.flen;
			unique case (n.state) inside
				S_METHOD: begin
					if (b == CH_SP) begin
						n.method = M_GET;
						for (int m = NUM_METHODS - 1; m >= 0; m--) begin
							if (p == METHOD_LENS[m] && n.mbytes == METHOD_NAMES[m])
								n.method = 3'(m);
						end
						n.state = S_METHOD_END;
					end else if (p >= FIELD_W'(cfg.max_method)) begin
						fail = 1'b1;
					end else begin
						if (p < FIELD_W'(MKEEP)) n.mbytes[p[2:0]] = b;
						n.flen = p + 1'b1;
						cls    = CLS_METHOD;
					end
				end
				S_PATH: begin
					if (b == CH_QMARK) begin
						n.state = S_QUERY;
						n.flen  = '0;
					end else if (b == CH_SP) begin
						n.state = S_PATH_END;
					end else if (p >= FIELD_W'(cfg.max_path)) begin
						fail = 1'b1;
					end else begin
						n.flen = p + 1'b1;
						cls    = CLS_PATH;
					end
				end
				S_QUERY: begin
					if (b == CH_SP) begin
						n.state = S_PATH_END;
					end else if (p >= FIELD_W'(cfg.max_query)) begin
						fail = 1'b1;
					end else begin
						n.flen = p + 1'b1;
						cls    = CLS_QUERY;
					end
				end
				S_VERSION: begin
					if (b == CH_CR) begin
						n.state = S_VERSION_CR;
					end else if (p >= FIELD_W'(cfg.max_version)) begin
						fail = 1'b1;
					end else begin
						n.flen = p + 1'b1;
						cls    = CLS_VERSION;
					end
				end
				S_VERSION_CR: begin
					if (b == CH_LF) n.state = S_VERSION_LF;
					else fail = 1'b1;
				end
				S_VERSION_LF, S_HLF: begin
					n.state = S_HEND_CR;
				end
				S_HNAME: begin
					if (b == CH_COLON) begin
						if (p != FIELD_W'(14)) n.nflags[0] = 1'b0;
						if (p != FIELD_W'(17)) n.nflags[1] = 1'b0;
						n.state = S_HCOLON;
					end else if (b == CH_CR) begin
						n.state = S_HEND_CR;
					end else if (p >= cfg.max_hfield) begin
						fail = 1'b1;
					end else begin
						if (!(p < FIELD_W'(14) && lb == NAME_CL[p[3:0]])) n.nflags[0] = 1'b0;
						if (!(p < FIELD_W'(17) && lb == NAME_TE[p[4:0]])) n.nflags[1] = 1'b0;
						n.flen = p + 1'b1;
						cls    = CLS_HNAME;
					end
				end
				S_HVALUE: begin
					if (b == CH_CR) begin
						n.state = S_HCR;
					end else if (p >= cfg.max_hfield) begin
						fail = 1'b1;
					end else begin
						if (n.dvalid) begin
							if (b < 8'h30 || b > 8'h39 || p >= FIELD_W'(20)) begin
								n.dvalid = 1'b0;
							end else begin
								dv = {1'b0, n.dacc, 3'b000} + {3'b000, n.dacc, 1'b0}
									+ (CLEN_W+4)'(b - 8'h30);
								if (dv > (CLEN_W+4)'(cfg.max_clen)) n.dvalid = 1'b0;
								else n.dacc = dv[CLEN_W-1:0];
							end
						end
						if (n.cpos < 3'd7) begin
							if (lb == WORD_CHUNKED[n.cpos]) n.cpos = n.cpos + 3'd1;
							else n.cpos = (lb == CH_C) ? 3'd1 : 3'd0;
						end
						n.flen = p + 1'b1;
						cls    = CLS_HVALUE;
					end
				end
				S_HCR: begin
					if (b == CH_LF) begin
						if (n.nflags[0]) n.clen = n.dvalid ? n.dacc : '0;
						if (n.nflags[1] && n.cpos == 3'd7) n.chunked = 1'b1;
						hl      = 1'b1;
						n.state = S_HLF;
					end else begin
						fail = 1'b1;
					end
				end
				S_HEND_CR: begin
					if (b == CH_LF) begin
						hd = 1'b1;
						if (n.chunked) begin
							n.state  = S_CSIZE;
							n.flen   = '0;
							n.csize  = '0;
							n.ccount = '0;
						end else if (n.clen != '0) begin
							n.state  = S_BODY;
							n.bcount = '0;
						end else begin
							n.state = S_COMPLETE;
						end
					end else begin
						fail = 1'b1;
					end
				end
				S_BODY: begin
					cls      = CLS_BODY;
					n.bcount = n.bcount + 1'b1;
					if (n.bcount >= n.clen) n.state = S_COMPLETE;
				end
				S_CSIZE: begin
					if (b == CH_CR || b == CH_SEMI) begin
						n.state = S_CSIZE_CR;
					end else if (hx[4]) begin
						if (p >= FIELD_W'(cfg.max_cdigits)) fail = 1'b1;
						else begin
							n.flen = p + 1'b1;
							if (n.csize[CHUNK_W-1 -: 4] != 4'd0) n.csize = '1;
							else n.csize = {n.csize[CHUNK_W-5:0], hx[3:0]};
						end
					end else if (b != CH_SP) begin
						fail = 1'b1;
					end
				end
				S_CSIZE_CR: if (b == CH_LF) n.state = S_CSIZE_LF;
				S_CDATA: begin
					cls      = CLS_BODY;
					n.ccount = n.ccount + 1'b1;
					if (n.ccount >= n.csize) n.state = S_CDATA_CR;
				end
				S_CDATA_CR: begin
					if (b == CH_CR) n.state = S_CDATA_LF;
					else fail = 1'b1;
				end
				S_CDATA_LF: begin
					if (b == CH_LF) begin
						n.state = S_CSIZE;
						n.flen  = '0;
						n.csize = '0;
					end else begin
						fail = 1'b1;
					end
				end
				S_TR_CR: n.state = (b == CH_CR) ? S_TR_LF : S_TR_SKIP;
				S_TR_SKIP: if (b == CH_CR) n.state = S_TR_SKIP_LF;
				S_TR_SKIP_LF: begin
					if (b == CH_LF) n.state = S_TR_CR;
					else fail = 1'b1;
				end
				S_TR_LF: begin
					if (b == CH_LF) n.state = S_COMPLETE;
					else fail = 1'b1;
				end
				default: ;
			endcase
			if (fail) begin
				n.err = 1'b1;
				cls   = CLS_SKIP;
			end
		end
	end

	always_comb begin
		res.cls     = cls;
		res.obyte   = action ? 8'd0 : data_byte;
		res.status  = n.err ? ST_ERROR : (n.state == S_COMPLETE ? ST_COMPLETE : ST_MORE);
		res.method  = n.method;
		res.clen    = n.clen;
		res.chunked = n.chunked;
		res.hl      = hl;
		res.hd      = hd;
	end

	assign ctx_next = n;

endmodule

FILE: rtl/core/http_request_stream_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_stream_parser_core
// Byte-serial HTTP/1.1 request parser with chunked body decoding.
// ----------------------------------------------------------------------------
// One request byte (or a restart, action = 1) enters per transaction on the
// in_valid/in_ready channel; every transaction yields exactly one result on
// the out_valid/out_ready channel: the byte class, the byte, the parse status
// and the decoded method, Content-Length and chunked flag.
// The path holds one input register and one result register, with the parse
// context updated as the byte moves from the first to the second. Throughput
// is one byte per cycle while the receiver does not stall on out_ready.
// Limits must be written on cfg_we/cfg_index/cfg_wdata only while the block
// is idle; the block itself does not enforce this. Reset loads the reset
// context and a default value into every limit.
// When the receiver stalls, the result register holds, the input register
// fills, and then in_ready drops; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module http_request_stream_parser_core import hrsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        byte_class,
	output logic [7:0]        out_byte,
	output logic [1:0]        status,
	output logic [2:0]        method_code,
	output logic [CLEN_W-1:0] body_length,
	output logic              chunked_mode,
	output logic              header_line_done,
	output logic              headers_done,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [26:0]       cfg_wdata
);

	cfg_t       cfg;
	ctx_t       ctx_q;
	ctx_t       ctx_d;
	res_t       res_d;
	res_t       res_s2;
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	logic       advance;
	logic       accept;

	hrsp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hrsp_step u_step (
		.ctx       (ctx_q),
		.cfg       (cfg),
		.action    (action_s1),
		.data_byte (byte_s1),
		.ctx_next  (ctx_d),
		.res       (res_d)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctx_q    <= CTX_RESET;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) begin
				valid_s2 <= 1'b1;
				ctx_q    <= ctx_d;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			byte_s1   <= data_byte;
		end
		if (advance) res_s2 <= res_d;
	end

	assign out_valid        = valid_s2;
	assign byte_class       = res_s2.cls;
	assign out_byte         = res_s2.obyte;
	assign status           = res_s2.status;
	assign method_code      = res_s2.method;
	assign body_length      = res_s2.clen;
	assign chunked_mode     = res_s2.chunked;
	assign header_line_done = res_s2.hl;
	assign headers_done     = res_s2.hd;

`ifndef NO_ASSERTIONS
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ctx_q.err && !action_s1) |=> ctx_q.err)
		else $error("error latch cleared without restart");

	a_line_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(header_line_done && headers_done))
		else $error("header line and header end flagged together");

	a_body_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_class == CLS_BODY) |-> status != ST_ERROR)
		else $error("body byte reported with error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_MORE || status == ST_COMPLETE || status == ST_ERROR))
		else $error("undefined status code");
`endif

endmodule
